// ===== rtl/wfdp_pkg.sv =====
`default_nettype none
package wfdp_pkg;

  localparam logic [7:0] SYNC1 = 8'h54;
  localparam logic [7:0] SYNC2 = 8'h3D;
  localparam logic [15:0] CRC_POLY = 16'h3D65;
  localparam logic [15:0] CRC_INIT = 16'h0000;
  localparam logic [7:0] CI_COMPACT = 8'h79;
  localparam logic [7:0] CI_LONG = 8'h78;
  localparam logic [7:0] MIN_LEN = 8'd18;
  localparam int unsigned MAX_FRAME_DEF = 64;
  localparam int unsigned QDEPTH = 4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_SYNC = 3'd1;
  localparam logic [2:0] ST_BAD_LEN = 3'd2;
  localparam logic [2:0] ST_ID_MISMATCH = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_CRC_BAD = 3'd5;
  localparam logic [2:0] ST_SHORT = 3'd6;

  localparam logic [1:0] REG_DEV_ID = 2'd0;
  localparam logic [1:0] REG_KEY_HIGH = 2'd1;
  localparam logic [1:0] REG_KEY_LOW = 2'd2;

  typedef enum logic [2:0] {
    OP_START,
    OP_ERR,
    OP_HDR,
    OP_DATA,
    OP_SKIP
  } op_e;

  typedef enum logic [1:0] {
    KIND_UNKNOWN,
    KIND_COMPACT,
    KIND_LONG
  } kind_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
    logic [7:0] idx;
    logic [7:0] len;
    logic [2:0] err;
    logic       last;
  } entry_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

endpackage
`default_nettype wire

// ===== rtl/wfdp_if.sv =====
`default_nettype none
interface wfdp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;
  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

interface wfdp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] total_litres;
  logic [31:0] month_start_litres;
  logic [7:0]  water_temp;
  logic [7:0]  air_temp;
  modport source (output valid, status, total_litres, month_start_litres, water_temp,
                  air_temp, input ready);
  modport sink (input valid, status, total_litres, month_start_litres, water_temp,
                air_temp, output ready);
endinterface
`default_nettype wire

// ===== rtl/wfdp_front.sv =====
`default_nettype none
module wfdp_front #(
  parameter int unsigned MAX_FRAME = wfdp_pkg::MAX_FRAME_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            accept_i,
  input  wire logic [7:0]      rx_byte_i,
  input  wire logic            frame_start_i,
  output wfdp_pkg::entry_t     entry_o,
  output logic                 push_o
);
  import wfdp_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SYNC2,
    PH_LEN,
    PH_PAYLOAD
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] idx_q, idx_d;
  logic [7:0] len_q, len_d;
  logic       sync_ok_q, sync_ok_d;
  logic [7:0] cl;
  logic [7:0] q;

  assign cl = len_q - MIN_LEN;
  assign q  = idx_q - 8'd16;

  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    len_d     = len_q;
    sync_ok_d = sync_ok_q;
    push_o    = 1'b0;
    entry_o   = '{op: OP_SKIP, data: rx_byte_i, idx: idx_q, len: len_q, err: ST_OK,
                  last: 1'b0};
    if (accept_i) begin
      if (frame_start_i) begin
        push_o     = 1'b1;
        entry_o.op = OP_START;
        sync_ok_d  = (rx_byte_i == SYNC1);
        phase_d    = PH_SYNC2;
      end else begin
        unique case (phase_q)
          PH_IDLE: begin
          end
          PH_SYNC2: begin
            if (!(sync_ok_q && rx_byte_i == SYNC2)) begin
              push_o       = 1'b1;
              entry_o.op   = OP_ERR;
              entry_o.err  = ST_BAD_SYNC;
              entry_o.last = 1'b1;
              phase_d      = PH_IDLE;
            end else begin
              phase_d = PH_LEN;
            end
          end
          PH_LEN: begin
            if (rx_byte_i < MIN_LEN || {1'b0, rx_byte_i} >= 9'(MAX_FRAME)) begin
              push_o       = 1'b1;
              entry_o.op   = OP_ERR;
              entry_o.err  = ST_BAD_LEN;
              entry_o.last = 1'b1;
              phase_d      = PH_IDLE;
            end else begin
              len_d   = rx_byte_i;
              idx_d   = '0;
              phase_d = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            push_o = 1'b1;
            if (idx_q < 8'd16) begin
              entry_o.op = OP_HDR;
            end else if (q < cl) begin
              entry_o.op  = OP_DATA;
              entry_o.idx = q;
            end else begin
              entry_o.op = OP_SKIP;
            end
            idx_d = idx_q + 8'd1;
            if ({1'b0, idx_q} + 9'd1 >= {1'b0, len_q}) begin
              entry_o.last = 1'b1;
              phase_d      = PH_IDLE;
            end
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      idx_q     <= '0;
      len_q     <= '0;
      sync_ok_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      len_q     <= len_d;
      sync_ok_q <= sync_ok_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wfdp_queue.sv =====
`default_nettype none
module wfdp_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire wfdp_pkg::entry_t entry_i,
  input  wire logic             pop_i,
  output wfdp_pkg::entry_t      entry_o,
  output logic                  empty_o,
  output logic                  full_o
);
  import wfdp_pkg::*;

  localparam int unsigned AW = $clog2(QDEPTH);

  entry_t         mem_q [QDEPTH];
  logic [AW-1:0]  wr_q, rd_q;
  logic [AW:0]    cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (AW+1)'(QDEPTH));
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + AW'(1);
      if (pop_i) rd_q <= rd_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wfdp_aes.sv =====
`default_nettype none
module wfdp_aes (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          abort_i,
  input  wire logic [127:0]  block_i,
  input  wire logic [127:0]  key_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [127:0]       block_o
);
  import wfdp_pkg::*;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] next_key(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = rk[127:96];
    w1 = rk[95:64];
    w2 = rk[63:32];
    w3 = rk[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = w0 ^ t;
    w1 = w1 ^ w0;
    w2 = w2 ^ w1;
    w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] round_f(input logic [127:0] s, input logic [127:0] rk,
                                           input logic fin);
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[j + 4*c] = SBOX[s[127 - 8*(j + 4*((c + j) & 3)) -: 8]];
      end
    end
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c];
        a1 = t[4*c+1];
        a2 = t[4*c+2];
        a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127 - 8*i -: 8] = t[i];
    end
    return r ^ rk;
  endfunction

  logic [127:0] st_q, rk_q, nk;
  logic [7:0]   rc_q;
  logic [3:0]   rnd_q;
  logic         busy_q, done_q;

  assign nk      = next_key(rk_q, rc_q);
  assign busy_o  = busy_q;
  assign done_o  = done_q;
  assign block_o = st_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      st_q <= block_i ^ key_i;
      rk_q <= key_i;
      rc_q <= 8'h01;
    end else if (busy_q) begin
      st_q <= round_f(st_q, nk, rnd_q == 4'd10);
      rk_q <= nk;
      rc_q <= xtime(rc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        rnd_q  <= 4'd1;
      end else if (abort_i) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 4'd1;
        if (rnd_q == 4'd10) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/wfdp_back.sv =====
`default_nettype none
module wfdp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire wfdp_pkg::entry_t entry_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  input  wire logic [31:0]     dev_id_i,
  input  wire logic [127:0]    key_i,
  wfdp_out_if.source           out_if
);
  import wfdp_pkg::*;

  function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  logic [7:0]   hdr_q [16];
  logic [127:0] ctr_q, ks_next_q, ks_cur_q, ctr_built, aes_in, aes_out;
  logic         ks_valid_q, aes_start, aes_abort, aes_busy, aes_done;
  logic [15:0]  crc_q, rcrc_q;
  kind_e        kind_q;
  logic         id_ok_q;
  logic [31:0]  tot_q, mon_q;
  logic [7:0]   wat_q, amb_q;
  logic         ov_q;
  logic [2:0]   st_q;
  logic [31:0]  ot_q, om_q;
  logic [7:0]   ow_q, oa_q;
  logic [3:0]   j;
  logic [7:0]   ks_byte, plain, q, cl;
  logic [2:0]   fin_st;
  logic         can_go;

  assign j  = entry_i.idx[3:0];
  assign q  = entry_i.idx;
  assign cl = entry_i.len - MIN_LEN;

  always_comb begin
    ctr_built = '0;
    for (int i = 0; i < 8; i++) begin
      ctr_built[127 - 8*i -: 8] = hdr_q[1 + i];
    end
    ctr_built[63:56] = hdr_q[10];
    for (int i = 0; i < 3; i++) begin
      ctr_built[55 - 8*i -: 8] = hdr_q[12 + i];
    end
    ctr_built[31:24] = entry_i.data;
  end

  assign ks_byte = (j == 4'd0) ? ks_next_q[127:120] : ks_cur_q[127 - 8*j -: 8];
  assign plain   = entry_i.data ^ ks_byte;

  assign can_go = !empty_i
                  && !(entry_i.op == OP_DATA && j == 4'd0 && !ks_valid_q)
                  && !(entry_i.last && ov_q && !out_if.ready);
  assign pop_o  = can_go;

  assign aes_start = pop_o && ((entry_i.op == OP_HDR && entry_i.idx == 8'd15)
                               || (entry_i.op == OP_DATA && j == 4'd0));
  assign aes_abort = pop_o && entry_i.op == OP_START;
  assign aes_in    = (entry_i.op == OP_HDR) ? ctr_built : ctr_q;

  wfdp_aes u_aes (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (aes_start),
    .abort_i (aes_abort),
    .block_i (aes_in),
    .key_i   (key_i),
    .busy_o  (aes_busy),
    .done_o  (aes_done),
    .block_o (aes_out)
  );

  always_comb begin
    if (entry_i.op == OP_ERR) begin
      fin_st = entry_i.err;
    end else if (!id_ok_q) begin
      fin_st = ST_ID_MISMATCH;
    end else if (cl < 8'd3) begin
      fin_st = ST_SHORT;
    end else if (kind_q == KIND_UNKNOWN) begin
      fin_st = ST_UNKNOWN;
    end else if (~crc_q != rcrc_q) begin
      fin_st = ST_CRC_BAD;
    end else if (kind_q == KIND_COMPACT && cl < 8'd19) begin
      fin_st = ST_SHORT;
    end else if (kind_q == KIND_LONG && cl < 8'd30) begin
      fin_st = ST_SHORT;
    end else begin
      fin_st = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.op == OP_HDR) begin
      hdr_q[entry_i.idx[3:0]] <= entry_i.data;
    end
    if (pop_o && entry_i.op == OP_DATA && j == 4'd0) begin
      ks_cur_q <= ks_next_q;
    end
    if (aes_done) begin
      ks_next_q <= aes_out;
    end
    if (pop_o && entry_i.last) begin
      st_q <= fin_st;
      ot_q <= (fin_st == ST_OK) ? tot_q : '0;
      om_q <= (fin_st == ST_OK) ? mon_q : '0;
      ow_q <= (fin_st == ST_OK) ? wat_q : '0;
      oa_q <= (fin_st == ST_OK) ? amb_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q      <= '0;
      ks_valid_q <= 1'b0;
      crc_q      <= CRC_INIT;
      rcrc_q     <= '0;
      kind_q     <= KIND_UNKNOWN;
      id_ok_q    <= 1'b1;
      tot_q      <= '0;
      mon_q      <= '0;
      wat_q      <= '0;
      amb_q      <= '0;
      ov_q       <= 1'b0;
    end else begin
      if (out_if.ready) ov_q <= 1'b0;
      if (pop_o && entry_i.last) ov_q <= 1'b1;
      if (aes_done) begin
        ks_valid_q <= 1'b1;
        ctr_q      <= ctr_q + 128'd1;
      end
      if (pop_o) begin
        unique case (entry_i.op)
          OP_START: begin
            ks_valid_q <= 1'b0;
            crc_q      <= CRC_INIT;
            rcrc_q     <= '0;
            kind_q     <= KIND_UNKNOWN;
            id_ok_q    <= 1'b1;
            tot_q      <= '0;
            mon_q      <= '0;
            wat_q      <= '0;
            amb_q      <= '0;
          end
          OP_HDR: begin
            if (entry_i.idx >= 8'd3 && entry_i.idx <= 8'd6
                && entry_i.data != dev_id_i[8*(entry_i.idx[2:0] - 3'd3) +: 8]) begin
              id_ok_q <= 1'b0;
            end
            if (entry_i.idx == 8'd15) begin
              ctr_q      <= ctr_built;
              ks_valid_q <= 1'b0;
            end
          end
          OP_DATA: begin
            if (j == 4'd0) ks_valid_q <= 1'b0;
            if (q == 8'd0) begin
              rcrc_q[7:0] <= plain;
            end else if (q == 8'd1) begin
              rcrc_q[15:8] <= plain;
            end else begin
              crc_q <= crc_step(crc_q, plain);
              if (q == 8'd2) begin
                kind_q <= (plain == CI_COMPACT) ? KIND_COMPACT
                        : (plain == CI_LONG) ? KIND_LONG : KIND_UNKNOWN;
              end
              if (kind_q == KIND_COMPACT) begin
                if (q >= 8'd9 && q <= 8'd12) tot_q[8*{q[1:0] - 2'd1} +: 8] <= plain;
                if (q >= 8'd13 && q <= 8'd16) mon_q[8*{q[1:0] - 2'd1} +: 8] <= plain;
                if (q == 8'd17) wat_q <= plain;
                if (q == 8'd18) amb_q <= plain;
              end else if (kind_q == KIND_LONG) begin
                if (q >= 8'd10 && q <= 8'd13) tot_q[8*{q[1:0] - 2'd2} +: 8] <= plain;
                if (q >= 8'd16 && q <= 8'd19) mon_q[8*q[1:0] +: 8] <= plain;
                if (q == 8'd23) wat_q <= plain;
                if (q == 8'd29) amb_q <= plain;
              end
            end
          end
          OP_ERR, OP_SKIP: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_if.valid              = ov_q;
  assign out_if.status             = st_q;
  assign out_if.total_litres       = ot_q;
  assign out_if.month_start_litres = om_q;
  assign out_if.water_temp         = ow_q;
  assign out_if.air_temp           = oa_q;

`ifndef SYNTHESIS
  a_ks_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && entry_i.op == OP_DATA && j == 4'd0 |-> ks_valid_q)
    else $error("keystream used before ready");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && entry_i.last |-> !ov_q || out_if.ready)
    else $error("result overwritten");
  a_busy_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(aes_busy && ks_valid_q && !aes_start))
    else $error("keystream valid while cipher busy");
  a_done_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aes_done && !pop_o |=> ks_valid_q)
    else $error("cipher result lost");
`endif

endmodule
`default_nettype wire

// ===== rtl/wmbus_frame_decrypt_parse_unit.sv =====
`default_nettype none
// encrypted meter frame decoder
// in_if carries one received byte per word; frame_start marks the first sync
// byte and drops any frame in progress. out_if carries one result word per
// frame: status, raw total and month-start litres and two temperatures.
// the front tracks sync, length and byte position and queues the start
// byte, errors and each payload byte with its role; the back checks the
// meter id, decrypts, runs the crc and captures fields. bytes are taken
// one per cycle except that the first payload byte of each 16-byte
// cipher block waits for the keystream: the iterative cipher starts on the
// last header byte, and later blocks are computed while the previous
// block streams in; a frame's result is registered when its last byte is taken.
// when the receiver stalls, the result is held in the output register and
// the input keeps flowing until the 4-word queue fills.
// reset clears all control state and sets the apb registers to zero.
// the apb port writes the device id at 0x00, key_high at 0x08, key_low at 0x10.
module wmbus_frame_decrypt_parse_unit #(
  parameter int unsigned MAX_FRAME = wfdp_pkg::MAX_FRAME_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  wfdp_in_if.sink           in_if,
  wfdp_out_if.source        out_if,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [4:0]   paddr,
  input  wire logic [63:0]  pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import wfdp_pkg::*;

  logic [31:0] dev_id_q;
  logic [63:0] key_hi_q, key_lo_q;
  entry_t      f_entry, q_entry;
  logic        push, pop, empty, full, accept;

  assign pready = 1'b1;
  assign in_if.ready = !full;
  assign accept = in_if.valid && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_id_q <= '0;
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:3])
        REG_DEV_ID:   dev_id_q <= pwdata[31:0];
        REG_KEY_HIGH: key_hi_q <= pwdata;
        REG_KEY_LOW:  key_lo_q <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:3])
      REG_DEV_ID:   prdata = {32'h0, dev_id_q};
      REG_KEY_HIGH: prdata = key_hi_q;
      REG_KEY_LOW:  prdata = key_lo_q;
      default:      prdata = '0;
    endcase
  end

  wfdp_front #(.MAX_FRAME(MAX_FRAME)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .rx_byte_i     (in_if.rx_byte),
    .frame_start_i (in_if.frame_start),
    .entry_o       (f_entry),
    .push_o        (push)
  );

  wfdp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .pop_i   (pop),
    .entry_o (q_entry),
    .empty_o (empty),
    .full_o  (full)
  );

  wfdp_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .entry_i  (q_entry),
    .empty_i  (empty),
    .pop_o    (pop),
    .dev_id_i (dev_id_q),
    .key_i    ({key_hi_q, key_lo_q}),
    .out_if   (out_if)
  );

endmodule
`default_nettype wire
